@@ rtl/pcm_pkg.sv @@
package pcm_pkg;

	// Item kinds carried on the input tuser.
	typedef enum logic [1:0] {
		CMD_WRITE   = 2'd0,
		CMD_NEAREST = 2'd1,
		CMD_EXACT   = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_EMIT
	} state_t;

	// One palette entry as held in the store, red in the lowest bits.
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	localparam int unsigned CMD_W     = 2;
	localparam int unsigned IN_DATA_W = 40;
	localparam int unsigned OUT_DATA_W = 40;
	localparam int unsigned DIST_W    = 18;
	localparam int unsigned SQ_W      = 16;

	// Colour returned for a read beyond the palette.
	localparam rgb_t ERROR_RGB = '{blue: 8'd255, green: 8'd0, red: 8'd255};

endpackage

@@ rtl/pcm_ram.sv @@
module pcm_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/palette_color_mapper_top.sv @@
// Channel   Direction  Signals                      Contents
// s_*       in         tvalid, tready, tdata, tuser  one command item
// m_*       out        tvalid, tready, tdata         one result item
//
// A write item gives no result. A read item within the palette goes through
// RD_ADDR and RD_DATA. A map item walks the palette store through its single
// read port, one entry a cycle; a map item with alpha zero skips the scan.
// The store is not cleared at reset. A result waits in the output register
// while the next item is taken; a stalled output only holds the block once
// the following result is ready.
module palette_color_mapper_top #(
	parameter int unsigned PALETTE_ENTRIES = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// entry_index[7:0], pixel_red[15:8], pixel_green[23:16],
	// pixel_blue[31:24], pixel_alpha[39:32]
	input  logic [pcm_pkg::IN_DATA_W-1:0]     s_tdata,
	// cmd[1:0]
	input  logic [pcm_pkg::CMD_W-1:0]         s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// color_index[7:0], transparent[8], matched[9], out_red[17:10],
	// out_green[25:18], out_blue[33:26], index_error[34], zero[39:35]
	output logic [pcm_pkg::OUT_DATA_W-1:0]    m_tdata
);

	import pcm_pkg::*;

	localparam int unsigned AW = $clog2(PALETTE_ENTRIES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);
	localparam logic [8:0] ENTRIES_9 = 9'(PALETTE_ENTRIES);

	state_t state_q, state_d;

	logic          s_fire;
	cmd_t          in_cmd;
	logic [7:0]    in_index;
	rgb_t          in_rgb;
	logic [7:0]    in_alpha;
	logic          in_range;

	cmd_t          cmd_q;
	logic [7:0]    idx_q;
	rgb_t          pix_q;
	logic          alpha_zero_q;
	logic          err_q;
	rgb_t          rd_rgb_q;

	logic [AW-1:0] addr_q;
	logic          v_s1;
	logic [AW-1:0] idx_s1;
	logic          v_s2;
	logic [AW-1:0] idx_s2;
	logic [SQ_W-1:0] sq_r_s2, sq_g_s2, sq_b_s2;
	logic          eq_s2;

	logic          have_q;
	logic          found_q;
	logic [AW-1:0] best_idx_q;
	logic [DIST_W-1:0] best_d_q;
	logic [DIST_W-1:0] dist_sum;

	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	rgb_t          ram_rdata;
	logic [23:0]   ram_rdata_raw;

	logic [7:0]    d_r, d_g, d_b;
	logic          out_free;
	logic [OUT_DATA_W-1:0] result;
	logic [7:0]    res_index;
	logic          res_transp, res_matched;
	rgb_t          res_rgb;
	logic          res_err;

	// Input field unpacking.
	assign in_cmd    = cmd_t'(s_tuser);
	assign in_index  = s_tdata[7:0];
	assign in_rgb    = '{blue: s_tdata[31:24], green: s_tdata[23:16], red: s_tdata[15:8]};
	assign in_alpha  = s_tdata[39:32];
	assign in_range  = {1'b0, in_index} < ENTRIES_9;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid || m_tready;

	// Palette store.
	assign ram_we    = s_fire && (in_cmd == CMD_WRITE) && in_range;
	assign ram_raddr = (state_q == ST_SCAN) ? addr_q : idx_q[AW-1:0];
	assign ram_rdata = rgb_t'(ram_rdata_raw);

	pcm_ram #(
		.WIDTH(24),
		.DEPTH(PALETTE_ENTRIES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(in_index[AW-1:0]),
		.wdata(in_rgb),
		.raddr(ram_raddr),
		.rdata(ram_rdata_raw)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					unique case (in_cmd)
						CMD_WRITE: state_d = ST_IDLE;
						CMD_READ:  state_d = in_range ? ST_RD_ADDR : ST_EMIT;
						CMD_NEAREST,
						CMD_EXACT: state_d = (in_alpha == 8'd0) ? ST_EMIT : ST_SCAN;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (addr_q == LAST_ADDR) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = ST_EMIT;
				end
			end
			ST_RD_ADDR: state_d = ST_RD_DATA;
			ST_RD_DATA: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Item capture and single-entry read.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_q        <= in_cmd;
			idx_q        <= in_index;
			pix_q        <= in_rgb;
			alpha_zero_q <= (in_alpha == 8'd0);
			err_q        <= (in_cmd == CMD_READ) && !in_range;
		end
		if (state_q == ST_RD_DATA) begin
			rd_rgb_q <= ram_rdata;
		end
	end

	// Scan address counter and stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			if (s_fire) begin
				addr_q <= '0;
			end else if (state_q == ST_SCAN) begin
				addr_q <= addr_q + AW'(1);
			end
			v_s1 <= (state_q == ST_SCAN);
			v_s2 <= v_s1;
		end
	end

	// Stage one: entry data arrives; take absolute differences and square them.
	assign d_r = (ram_rdata.red > pix_q.red) ? ram_rdata.red - pix_q.red
	                                         : pix_q.red - ram_rdata.red;
	assign d_g = (ram_rdata.green > pix_q.green) ? ram_rdata.green - pix_q.green
	                                             : pix_q.green - ram_rdata.green;
	assign d_b = (ram_rdata.blue > pix_q.blue) ? ram_rdata.blue - pix_q.blue
	                                           : pix_q.blue - ram_rdata.blue;

	always_ff @(posedge clk) begin
		idx_s1  <= addr_q;
		idx_s2  <= idx_s1;
		sq_r_s2 <= SQ_W'(d_r) * SQ_W'(d_r);
		sq_g_s2 <= SQ_W'(d_g) * SQ_W'(d_g);
		sq_b_s2 <= SQ_W'(d_b) * SQ_W'(d_b);
		eq_s2   <= (ram_rdata == pix_q);
	end

	// Stage two: sum the squares and keep the best entry so far.
	assign dist_sum = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q  <= 1'b0;
			found_q <= 1'b0;
		end else if (s_fire) begin
			have_q  <= 1'b0;
			found_q <= 1'b0;
		end else if (v_s2) begin
			if (cmd_q == CMD_NEAREST) begin
				have_q <= 1'b1;
			end else if (eq_s2) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			best_idx_q <= '0;
		end else if (v_s2) begin
			if (cmd_q == CMD_NEAREST) begin
				if (!have_q || dist_sum < best_d_q) begin
					best_idx_q <= idx_s2;
					best_d_q   <= dist_sum;
				end
			end else if (eq_s2 && !found_q) begin
				best_idx_q <= idx_s2;
			end
		end
	end

	// Result composition for the finished item.
	always_comb begin
		res_index   = 8'd0;
		res_transp  = 1'b0;
		res_matched = 1'b0;
		res_rgb     = '0;
		res_err     = 1'b0;
		if (cmd_q == CMD_READ) begin
			res_rgb = err_q ? ERROR_RGB : rd_rgb_q;
			res_err = err_q;
		end else if (alpha_zero_q) begin
			res_transp = 1'b1;
		end else if (cmd_q == CMD_NEAREST) begin
			res_index = 8'(best_idx_q);
		end else begin
			res_matched = found_q;
			res_index   = found_q ? 8'(best_idx_q) : 8'd0;
		end
		result = {5'd0, res_err, res_rgb.blue, res_rgb.green, res_rgb.red,
		          res_matched, res_transp, res_index};
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			m_tdata <= result;
		end
	end

endmodule

@@ dv/palette_map_checker.sv @@
module palette_map_checker #(
	parameter int unsigned PALETTE_ENTRIES = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [pcm_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [pcm_pkg::CMD_W-1:0]      s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [pcm_pkg::OUT_DATA_W-1:0] m_tdata,
	output int                             mismatches,
	output int                             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import pcm_pkg::*;

	// Fields of one command item as packed on s_tdata.
	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] entry_index;
	} pixel_item_t;

	// Fields of one result item as packed on m_tdata.
	typedef struct packed {
		logic [4:0] pad;
		logic       index_error;
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic       matched;
		logic       transparent;
		logic [7:0] color_index;
	} map_result_t;

	rgb_t        palette_copy [256];
	map_result_t expected_results [$];
	int          fail_tally = 0;
	int          pending_total = 0;

	assign mismatches  = fail_tally;
	assign outstanding = pending_total;

	// Works out the result of a map or read item from the mirrored palette.
	function automatic map_result_t predict_result(cmd_t kind, pixel_item_t px);
		map_result_t res;
		int          dr;
		int          dg;
		int          db;
		int          sq_dist;
		int          best_dist;
		int          best_entry;
		res        = '0;
		best_dist  = 0;
		best_entry = 0;
		if (kind == CMD_READ) begin
			if (px.entry_index < PALETTE_ENTRIES) begin
				res.out_red   = palette_copy[px.entry_index].red;
				res.out_green = palette_copy[px.entry_index].green;
				res.out_blue  = palette_copy[px.entry_index].blue;
			end else begin
				res.out_red     = ERROR_RGB.red;
				res.out_green   = ERROR_RGB.green;
				res.out_blue    = ERROR_RGB.blue;
				res.index_error = 1'b1;
			end
		end else if (px.alpha == 8'd0) begin
			res.transparent = 1'b1;
		end else if (kind == CMD_NEAREST) begin
			// Strictly smaller distance only, so the lowest index wins a tie.
			for (int i = 0; i < PALETTE_ENTRIES; i++) begin
				dr      = int'(palette_copy[i].red) - int'(px.red);
				dg      = int'(palette_copy[i].green) - int'(px.green);
				db      = int'(palette_copy[i].blue) - int'(px.blue);
				sq_dist = dr * dr + dg * dg + db * db;
				if (i == 0 || sq_dist < best_dist) begin
					best_dist  = sq_dist;
					best_entry = i;
				end
			end
			res.color_index = 8'(best_entry);
		end else begin
			// Walking downwards leaves the first equal entry in place.
			for (int i = PALETTE_ENTRIES - 1; i >= 0; i--) begin
				if (palette_copy[i].red == px.red && palette_copy[i].green == px.green
						&& palette_copy[i].blue == px.blue) begin
					res.color_index = 8'(i);
					res.matched     = 1'b1;
				end
			end
		end
		return res;
	endfunction

	task automatic check_field(string field, int unsigned want, int unsigned got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fail_tally++;
		end
	endtask

	// Results are compared before the item of the same edge is predicted,
	// since no result can leave in the cycle its item arrives.
	always @(posedge clk) begin
		pixel_item_t px;
		map_result_t got;
		map_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_results.size() == 0) begin
					$error("m_tdata: expected no result, got %h", m_tdata);
					fail_tally++;
				end else begin
					want = expected_results.pop_front();
					check_field("color_index", want.color_index, got.color_index);
					check_field("transparent", want.transparent, got.transparent);
					check_field("matched", want.matched, got.matched);
					check_field("out_red", want.out_red, got.out_red);
					check_field("out_green", want.out_green, got.out_green);
					check_field("out_blue", want.out_blue, got.out_blue);
					check_field("index_error", want.index_error, got.index_error);
					check_field("pad", want.pad, got.pad);
				end
			end
			if (s_tvalid && s_tready) begin
				px = s_tdata;
				if (cmd_t'(s_tuser) == CMD_WRITE) begin
					if (px.entry_index < PALETTE_ENTRIES)
						palette_copy[px.entry_index] =
							'{blue: px.blue, green: px.green, red: px.red};
				end else begin
					expected_results.push_back(predict_result(cmd_t'(s_tuser), px));
				end
			end
			pending_total = expected_results.size();
		end
	end

endmodule

@@ dv/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pcm_pkg::*;

	localparam int unsigned ENTRIES      = 256;
	localparam int          RANDOM_ITEMS = 520;
	localparam int          PHASES       = 4;
	localparam int          CYCLE_LIMIT  = 1_500_000;

	// Two colours equally far from a third, used to force nearest-map ties.
	localparam rgb_t TIE_LOW   = '{blue: 8'd0, green: 8'd0, red: 8'd100};
	localparam rgb_t TIE_HIGH  = '{blue: 8'd0, green: 8'd0, red: 8'd110};
	localparam rgb_t TIE_PIXEL = '{blue: 8'd0, green: 8'd0, red: 8'd105};
	localparam rgb_t BLACK     = '{blue: 8'd0, green: 8'd0, red: 8'd0};
	localparam rgb_t WHITE     = '{blue: 8'd255, green: 8'd255, red: 8'd255};
	localparam rgb_t MAGENTA   = '{blue: 8'd255, green: 8'd0, red: 8'd255};
	localparam rgb_t TEAL      = '{blue: 8'd56, green: 8'd34, red: 8'd12};

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic [CMD_W-1:0]      s_tuser  = CMD_WRITE;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	int   mismatches;
	int   outstanding;
	int   cycle_count = 0;
	bit   idle_on     = 1'b1;
	rgb_t palette_shadow [256];

	palette_color_mapper_top #(
		.PALETTE_ENTRIES(ENTRIES)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	palette_map_checker #(
		.PALETTE_ENTRIES(ENTRIES)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	// Clock with a 4 ns period.
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// The result side stalls at random while idling is enabled.
	always @(negedge clk) begin
		m_tready <= arst_n && !(idle_on && $urandom_range(99) < 14);
	end

	// Guard against a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Mostly uniform bytes, with the two extremes favoured.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic rgb_t pick_colour();
		rgb_t c;
		c.red   = pick_byte();
		c.green = pick_byte();
		c.blue  = pick_byte();
		return c;
	endfunction

	function automatic logic [7:0] pick_alpha();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(254, 1));
		endcase
	endfunction

	// Moves one channel by up to three steps, clamped to the byte range.
	function automatic logic [7:0] nudge(logic [7:0] v);
		int t;
		t = int'(v) + int'($urandom_range(6)) - 3;
		if (t < 0)
			t = 0;
		if (t > 255)
			t = 255;
		return 8'(t);
	endfunction

	function automatic rgb_t near_colour(rgb_t base);
		rgb_t c;
		c.red   = nudge(base.red);
		c.green = nudge(base.green);
		c.blue  = nudge(base.blue);
		return c;
	endfunction

	// Palette of few distinct colours, so duplicates and ties are common.
	function automatic rgb_t few_colour();
		case ($urandom_range(3))
			0: return TIE_LOW;
			1: return TIE_HIGH;
			2: return BLACK;
			default: return WHITE;
		endcase
	endfunction

	function automatic bit in_palette(rgb_t c);
		for (int i = 0; i < ENTRIES; i++)
			if (palette_shadow[i] == c)
				return 1'b1;
		return 1'b0;
	endfunction

	// Presents one item from the falling edge and returns once it is taken.
	task automatic send_item(cmd_t kind, logic [7:0] idx, rgb_t colour, logic [7:0] alpha);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 14) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {alpha, colour.blue, colour.green, colour.red, idx};
		if (kind == CMD_WRITE)
			palette_shadow[idx] = colour;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Drops valid and waits until every result has come back.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// Every entry is written before any map item scans the store.
	task automatic fill_palette(bit few_colours);
		for (int i = 0; i < ENTRIES; i++)
			send_item(CMD_WRITE, 8'(i), few_colours ? few_colour() : pick_colour(),
				pick_alpha());
	endtask

	task automatic random_item(bit few_colours);
		int   sel;
		rgb_t c;
		sel = $urandom_range(99);
		if (sel < 20) begin
			c = few_colours ? few_colour() : pick_colour();
			send_item(CMD_WRITE, 8'($urandom_range(255)), c, 8'($urandom_range(255)));
		end else if (sel < 55) begin
			case ($urandom_range(2))
				0: c = pick_colour();
				1: c = near_colour(palette_shadow[$urandom_range(255)]);
				default: c = few_colours ? TIE_PIXEL : pick_colour();
			endcase
			send_item(CMD_NEAREST, 8'($urandom_range(255)), c, pick_alpha());
		end else if (sel < 80) begin
			if ($urandom_range(9) < 6)
				c = palette_shadow[$urandom_range(255)];
			else
				c = pick_colour();
			send_item(CMD_EXACT, 8'($urandom_range(255)), c, pick_alpha());
		end else begin
			send_item(CMD_READ, 8'($urandom_range(255)), pick_colour(), pick_alpha());
		end
	endtask

	initial begin
		rgb_t absent;

		// Reset once, released on a falling edge.
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		fill_palette(1'b0);

		// Directed items: extremes, duplicates, transparency and misses.
		absent = pick_colour();
		while (in_palette(absent) || absent == TEAL)
			absent = pick_colour();
		send_item(CMD_WRITE, 8'd10, TEAL, 8'd0);
		send_item(CMD_WRITE, 8'd200, TEAL, 8'd255);
		send_item(CMD_WRITE, 8'd0, BLACK, 8'd0);
		send_item(CMD_WRITE, 8'd255, WHITE, 8'd255);
		send_item(CMD_NEAREST, 8'd0, BLACK, 8'd255);
		send_item(CMD_NEAREST, 8'd255, WHITE, 8'd1);
		send_item(CMD_NEAREST, 8'd0, TEAL, 8'd0);
		send_item(CMD_EXACT, 8'd0, TEAL, 8'd128);
		send_item(CMD_EXACT, 8'd255, WHITE, 8'd0);
		send_item(CMD_EXACT, 8'd0, absent, 8'd255);
		send_item(CMD_NEAREST, 8'd0, absent, 8'd255);
		send_item(CMD_READ, 8'd0, WHITE, 8'd255);
		send_item(CMD_READ, 8'd10, BLACK, 8'd0);
		send_item(CMD_READ, 8'd200, BLACK, 8'd0);
		send_item(CMD_READ, 8'd255, BLACK, 8'd0);
		send_item(CMD_WRITE, 8'd255, MAGENTA, 8'd0);
		send_item(CMD_READ, 8'd255, WHITE, 8'd255);
		send_item(CMD_EXACT, 8'd0, MAGENTA, 8'd255);
		send_item(CMD_NEAREST, 8'd0, MAGENTA, 8'd255);
		drain_results();

		// Random phases; the second runs without any idling on either side,
		// the third works on a palette of few colours.
		for (int ph = 0; ph < PHASES; ph++) begin
			idle_on = (ph != 1);
			if (ph == 2)
				fill_palette(1'b1);
			if (ph == 3)
				fill_palette(1'b0);
			repeat (RANDOM_ITEMS / PHASES)
				random_item(ph == 2);
			drain_results();
		end

		// Allow for any late or stray result before the verdict.
		repeat (ENTRIES + 16)
			@(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
